// ----- src/sfcc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcc_pkg: shared types and constants of the sensor frame CRC checker
// Frame layout, CRC-16 constants and the one-byte CRC update function.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcc_pkg;

  // Field widths.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COUNT_W = 3;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] byte_pos_t;

  // Reflected CRC-16 with polynomial 0xA001, seeded with all ones.
  localparam word_t CRC_INIT = 16'hFFFF;
  localparam word_t CRC_POLY = 16'hA001;

  // Byte positions within the 8-byte reply frame.
  localparam byte_pos_t POS_FIRST   = 3'd0;
  localparam byte_pos_t POS_HUM_HI  = 3'd2;
  localparam byte_pos_t POS_HUM_LO  = 3'd3;
  localparam byte_pos_t POS_TEMP_HI = 3'd4;
  localparam byte_pos_t POS_TEMP_LO = 3'd5;
  localparam byte_pos_t POS_CRC_LO  = 3'd6;
  localparam byte_pos_t POS_CRC_HI  = 3'd7;

  // Temperature high byte: sign in bit 7, magnitude in bits 6..0.
  localparam int unsigned TEMP_SIGN_BIT = 7;

  // One byte through the reflected CRC, one bit per step.
  function automatic word_t crc_update(input word_t crc_in, input byte_t data);
    word_t crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// ----- src/sfcc_if.sv -----
// ----------------------------------------------------------------------------
// sfcc_if: stream interfaces of the sensor frame CRC checker
// Byte channel into the checker and decoded result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

// Received frame bytes.
interface sfcc_in_if;
  logic                valid;
  logic                ready;
  sfcc_pkg::byte_t     rx_byte;
  logic                frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Decoded frame results.
interface sfcc_out_if;
  logic                valid;
  logic                ready;
  sfcc_pkg::word_t     humidity_tenths;
  logic signed [15:0]  temperature_tenths;
  logic                crc_ok;

  modport source (output valid, output humidity_tenths, output temperature_tenths,
                  output crc_ok, input ready);
  modport sink   (input valid, input humidity_tenths, input temperature_tenths,
                  input crc_ok, output ready);
endinterface

`default_nettype wire

// ----- src/sensor_frame_crc_checker.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker: reply frame decoder with CRC-16 check
// Collects the 8-byte sensor frame, checks its CRC and emits one decoded
// result (humidity, signed temperature, CRC flag) per frame.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                     Beats
//   in_ch     input      rx_byte[7:0], frame_start                   one per byte
//   out_ch    output     humidity_tenths, temperature_tenths, crc_ok one per frame
//
// A byte can be accepted on every cycle unless a result waits on a stalled sink.
// The CRC update of a byte is an unrolled 8-step shift/xor between the byte
// beat and the CRC register, which sets the cycle time.
// The result of a frame is registered and shows in the cycle after its last byte.
// While a result waits on a stalled sink, in_ch.ready is low and no byte is
// taken; a sink that takes the result in a cycle lets a byte in that cycle.
// Synchronous active-low reset clears the byte count, holds and result valid and reseeds the CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_crc_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sfcc_in_if.sink     in_ch,
  sfcc_out_if.source  out_ch
);

  // Frame state.
  sfcc_pkg::byte_pos_t byte_count_r, byte_count_nxt;
  sfcc_pkg::word_t     crc_r, crc_nxt;
  sfcc_pkg::word_t     humidity_hold_r, humidity_hold_nxt;
  sfcc_pkg::word_t     temperature_hold_r, temperature_hold_nxt;
  sfcc_pkg::byte_t     crc_low_hold_r, crc_low_hold_nxt;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  sfcc_pkg::word_t     humidity_r, humidity_nxt;
  logic signed [15:0]  temperature_r, temperature_nxt;
  logic                crc_ok_r, crc_ok_nxt;

  logic                in_fire;
  sfcc_pkg::byte_pos_t pos;
  sfcc_pkg::word_t     crc_base;
  sfcc_pkg::word_t     crc_stepped;
  sfcc_pkg::word_t     crc_received;
  logic [14:0]         temp_mag;

  // Input is blocked only while a result waits and the sink is not taking it.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // A start flag forces the byte to position zero with a fresh CRC.
  assign pos      = in_ch.frame_start ? sfcc_pkg::POS_FIRST : byte_count_r;
  assign crc_base = in_ch.frame_start ? sfcc_pkg::CRC_INIT : crc_r;

  assign crc_stepped  = sfcc_pkg::crc_update(crc_base, in_ch.rx_byte);
  assign crc_received = {in_ch.rx_byte, crc_low_hold_r};
  assign temp_mag     = {temperature_hold_r[14:8], temperature_hold_r[7:0]};

  // Byte decode and state update.
  always_comb begin
    byte_count_nxt       = byte_count_r;
    crc_nxt              = crc_r;
    humidity_hold_nxt    = humidity_hold_r;
    temperature_hold_nxt = temperature_hold_r;
    crc_low_hold_nxt     = crc_low_hold_r;
    out_valid_nxt        = out_valid_r && !out_ch.ready;
    humidity_nxt         = humidity_r;
    temperature_nxt      = temperature_r;
    crc_ok_nxt           = crc_ok_r;

    if (in_fire) begin
      byte_count_nxt = pos + 3'd1;
      if (pos < sfcc_pkg::POS_CRC_LO) begin
        crc_nxt = crc_stepped;
      end else begin
        crc_nxt = crc_base;
      end
      unique case (pos)
        sfcc_pkg::POS_HUM_HI:  humidity_hold_nxt[15:8]    = in_ch.rx_byte;
        sfcc_pkg::POS_HUM_LO:  humidity_hold_nxt[7:0]     = in_ch.rx_byte;
        sfcc_pkg::POS_TEMP_HI: temperature_hold_nxt[15:8] = in_ch.rx_byte;
        sfcc_pkg::POS_TEMP_LO: temperature_hold_nxt[7:0]  = in_ch.rx_byte;
        sfcc_pkg::POS_CRC_LO:  crc_low_hold_nxt           = in_ch.rx_byte;
        sfcc_pkg::POS_CRC_HI: begin
          // Last byte: build the result and reseed the CRC for the next frame.
          out_valid_nxt = 1'b1;
          humidity_nxt  = humidity_hold_r;
          if (temperature_hold_r[8 + sfcc_pkg::TEMP_SIGN_BIT]) begin
            temperature_nxt = -$signed({1'b0, temp_mag});
          end else begin
            temperature_nxt = $signed({1'b0, temp_mag});
          end
          crc_ok_nxt = (crc_base == crc_received);
          crc_nxt    = sfcc_pkg::CRC_INIT;
        end
        default: ;
      endcase
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r       <= sfcc_pkg::POS_FIRST;
      crc_r              <= sfcc_pkg::CRC_INIT;
      humidity_hold_r    <= '0;
      temperature_hold_r <= '0;
      crc_low_hold_r     <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      byte_count_r       <= byte_count_nxt;
      crc_r              <= crc_nxt;
      humidity_hold_r    <= humidity_hold_nxt;
      temperature_hold_r <= temperature_hold_nxt;
      crc_low_hold_r     <= crc_low_hold_nxt;
      out_valid_r        <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    humidity_r    <= humidity_nxt;
    temperature_r <= temperature_nxt;
    crc_ok_r      <= crc_ok_nxt;
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.humidity_tenths    = humidity_r;
  assign out_ch.temperature_tenths = temperature_r;
  assign out_ch.crc_ok             = crc_ok_r;

  // The last byte of a frame always yields a result in the next cycle.
  a_last_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pos == sfcc_pkg::POS_CRC_HI |=> out_valid_r)
    else $error("frame end did not produce a result");

  // Any other byte leaves no result pending.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pos != sfcc_pkg::POS_CRC_HI |=> !out_valid_r)
    else $error("result raised on a byte that is not the frame end");

  // The CRC is reseeded after the frame end.
  a_crc_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pos == sfcc_pkg::POS_CRC_HI |=> crc_r == sfcc_pkg::CRC_INIT)
    else $error("CRC not reseeded after frame end");

  // A start flag places the next byte at position one.
  a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.frame_start |=> byte_count_r == 3'd1)
    else $error("start flag did not restart the byte count");

endmodule

`default_nettype wire
